// ===== hw/rtl/fcrp_pkg.sv =====
// ============================================================================
// fcrp_pkg
// Shared constants for the FastCGI response record parser.
// ============================================================================
`default_nettype none

package fcrp_pkg;

    // Record header fields
    localparam logic [7:0]  REC_VERSION      = 8'd1;
    localparam logic [7:0]  REC_END_REQ      = 8'd3;
    localparam logic [7:0]  REC_STDOUT       = 8'd6;
    localparam logic [7:0]  REC_STDERR       = 8'd7;
    localparam logic [15:0] END_BODY_LEN     = 16'd8;

    // Header byte positions
    localparam logic [2:0] HDR_VERSION  = 3'd0;
    localparam logic [2:0] HDR_TYPE     = 3'd1;
    localparam logic [2:0] HDR_RID_HI   = 3'd2;
    localparam logic [2:0] HDR_RID_LO   = 3'd3;
    localparam logic [2:0] HDR_CLEN_HI  = 3'd4;
    localparam logic [2:0] HDR_CLEN_LO  = 3'd5;
    localparam logic [2:0] HDR_PAD      = 3'd6;
    localparam logic [2:0] HDR_RESERVED = 3'd7;

    // Status bytes sit while content_left (before decrement) is 8..5
    localparam logic [15:0] STATUS_LAST_LEFT = 16'd5;

    // Result kinds
    localparam logic [1:0] KIND_STDOUT = 2'd0;
    localparam logic [1:0] KIND_STDERR = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_VERSION = 2'd0;
    localparam logic [1:0] ERR_REQ_ID  = 2'd1;
    localparam logic [1:0] ERR_END_LEN = 2'd2;
    localparam logic [1:0] ERR_TYPE    = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/fcrp_if.sv =====
// ============================================================================
// fcrp_rx_if / fcrp_res_if
// Valid/ready channels of the parser: worker bytes in, results out.
// ============================================================================
`default_nettype none

interface fcrp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fcrp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] app_status;
    logic [1:0]  error_code;

    modport source (output valid, output kind, output data_byte, output app_status,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input data_byte, input app_status,
                    input error_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fastcgi_response_record_parser_top.sv =====
// ============================================================================
// fastcgi_response_record_parser_top
// Deframes the FastCGI byte stream returned by a worker into tagged results.
// ============================================================================
//
//  Channel  Dir  Handshake      Transaction
//  -------  ---  -------------  -----------------------------------------------
//  i_rx     in   valid/ready    one received stream byte (rx_byte)
//  o_res    out  valid/ready    kind, data_byte, app_status, error_code
//  i_cfg_*  in   write enable   expected request id, 16 bits
//
//  One byte per cycle: each accepted byte updates the header/count state and
//  loads at most one result into the output register in the same cycle.
//  i_rx.ready is high while the output register is empty or being drained,
//  so a waiting result does not stop the stream unless o_res stalls too.
//  Reset (i_rst_n low at a clock edge) clears header phase, counters, the
//  finished and error flags, the request id register and the output valid.
//  After a finished or error result every byte is swallowed until reset.
//
`default_nettype none

module fastcgi_response_record_parser_top
    import fcrp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    fcrp_rx_if.sink     i_rx,
    fcrp_res_if.source  o_res
);

    // Configuration
    logic [15:0] r_exp_rid;

    // Header gather / body state
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic        r_in_body, n_in_body;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_type, n_type;        // doubles as record type in the body
    logic [15:0] r_rid, n_rid;
    logic [15:0] r_content_left, n_content_left;
    logic [7:0]  r_padding_left, n_padding_left;
    logic [31:0] r_status, n_status;
    logic        r_finished, n_finished;
    logic        r_error, n_error;

    // Output register
    logic        r_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [7:0]  r_data, n_data;
    logic [31:0] r_exit, n_exit;
    logic [1:0]  r_code, n_code;
    logic        n_emit;

    logic        in_fire;
    logic [15:0] content_dec;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign in_fire    = i_rx.valid && i_rx.ready;
    assign content_dec = r_content_left - 16'd1;

    // Per-byte update
    always_comb begin
        n_hdr_cnt      = r_hdr_cnt;
        n_in_body      = r_in_body;
        n_version      = r_version;
        n_type         = r_type;
        n_rid          = r_rid;
        n_content_left = r_content_left;
        n_padding_left = r_padding_left;
        n_status       = r_status;
        n_finished     = r_finished;
        n_error        = r_error;
        n_emit         = 1'b0;
        n_kind         = KIND_STDOUT;
        n_data         = 8'd0;
        n_exit         = 32'd0;
        n_code         = ERR_VERSION;

        if (!(r_finished || r_error)) begin
            if (!r_in_body) begin
                // Header phase: gather bytes, check on the last one
                n_hdr_cnt = r_hdr_cnt + 3'd1;
                case (r_hdr_cnt)
                    HDR_VERSION: n_version = i_rx.rx_byte;
                    HDR_TYPE:    n_type    = i_rx.rx_byte;
                    HDR_RID_HI:  n_rid[15:8] = i_rx.rx_byte;
                    HDR_RID_LO:  n_rid[7:0]  = i_rx.rx_byte;
                    HDR_CLEN_HI: n_content_left[15:8] = i_rx.rx_byte;
                    HDR_CLEN_LO: n_content_left[7:0]  = i_rx.rx_byte;
                    HDR_PAD:     n_padding_left = i_rx.rx_byte;
                    HDR_RESERVED: begin
                        n_status = 32'd0;
                        if (r_version != REC_VERSION) begin
                            n_error = 1'b1;
                            n_emit  = 1'b1;
                            n_kind  = KIND_ERROR;
                            n_code  = ERR_VERSION;
                        end else if (r_rid != r_exp_rid) begin
                            n_error = 1'b1;
                            n_emit  = 1'b1;
                            n_kind  = KIND_ERROR;
                            n_code  = ERR_REQ_ID;
                        end else if (r_type != REC_STDOUT && r_type != REC_STDERR &&
                                     r_type != REC_END_REQ) begin
                            n_error = 1'b1;
                            n_emit  = 1'b1;
                            n_kind  = KIND_ERROR;
                            n_code  = ERR_TYPE;
                        end else if (r_type == REC_END_REQ &&
                                     r_content_left != END_BODY_LEN) begin
                            n_error = 1'b1;
                            n_emit  = 1'b1;
                            n_kind  = KIND_ERROR;
                            n_code  = ERR_END_LEN;
                        end else begin
                            // Empty record completes here
                            n_in_body = (r_content_left != 16'd0) || (r_padding_left != 8'd0);
                        end
                    end
                    default: ;
                endcase
            end else begin
                if (r_content_left != 16'd0) begin
                    n_content_left = content_dec;
                    if (r_type == REC_STDOUT) begin
                        n_emit = 1'b1;
                        n_kind = KIND_STDOUT;
                        n_data = i_rx.rx_byte;
                    end else if (r_type == REC_STDERR) begin
                        n_emit = 1'b1;
                        n_kind = KIND_STDERR;
                        n_data = i_rx.rx_byte;
                    end else begin
                        // End request body: first four bytes are the status
                        if (r_content_left >= STATUS_LAST_LEFT) begin
                            n_status = {r_status[23:0], i_rx.rx_byte};
                        end
                        if (content_dec == 16'd0) begin
                            n_finished = 1'b1;
                            n_emit     = 1'b1;
                            n_kind     = KIND_DONE;
                            n_exit     = r_status;
                        end
                    end
                end else if (r_padding_left != 8'd0) begin
                    n_padding_left = r_padding_left - 8'd1;
                end
                if (n_content_left == 16'd0 && n_padding_left == 8'd0) begin
                    n_in_body = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_rid      <= 16'd0;
            r_hdr_cnt      <= 3'd0;
            r_in_body      <= 1'b0;
            r_version      <= 8'd0;
            r_type         <= 8'd0;
            r_rid          <= 16'd0;
            r_content_left <= 16'd0;
            r_padding_left <= 8'd0;
            r_status       <= 32'd0;
            r_finished     <= 1'b0;
            r_error        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_exp_rid <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_hdr_cnt      <= n_hdr_cnt;
                r_in_body      <= n_in_body;
                r_version      <= n_version;
                r_type         <= n_type;
                r_rid          <= n_rid;
                r_content_left <= n_content_left;
                r_padding_left <= n_padding_left;
                r_status       <= n_status;
                r_finished     <= n_finished;
                r_error        <= n_error;
                r_out_valid    <= n_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_kind <= n_kind;
            r_data <= n_data;
            r_exit <= n_exit;
            r_code <= n_code;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.data_byte   = r_data;
    assign o_res.app_status  = r_exit;
    assign o_res.error_code  = r_code;

`ifndef NO_ASSERTIONS
    // Once finished or failed, accepted bytes must not produce results
    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished || r_error) && in_fire |=> !r_out_valid)
        else $error("result produced after finish/error");

    // Body phase only while something is left to consume
    a_body_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_body |-> (r_content_left != 16'd0 || r_padding_left != 8'd0))
        else $error("body phase with nothing left");

    // A finished result always matches the sticky finished flag
    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == KIND_DONE |-> r_finished)
        else $error("finished result without finished flag");

    // An error result always matches the sticky error flag
    a_error_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == KIND_ERROR |-> r_error && !r_in_body)
        else $error("error result without error flag");
`endif

endmodule

`default_nettype wire

// ===== test/fcrp_deframe_check.sv =====
// ============================================================================
// fcrp_deframe_check
// Watches the byte and result channels of the FastCGI response parser,
// predicts every result from the accepted bytes and compares in order.
// ============================================================================
`default_nettype none

module fcrp_deframe_check
    import fcrp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    fcrp_rx_if          i_rx,
    fcrp_res_if         i_res,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] app_status;
        logic [1:0]  error_code;
    } t_result;

    t_result expected_results[$];

    // Deframer state
    logic [15:0] req_id;
    logic [7:0]  hdr [8];
    logic [3:0]  hdr_cnt;
    logic [15:0] content_left;
    logic [7:0]  pad_left;
    logic [7:0]  rec_type;
    logic [31:0] status_acc;
    logic        done_flag;
    logic        err_flag;

    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] data,
                                         input logic [31:0] status, input logic [1:0] code);
        t_result r;
        r.kind        = kind;
        r.data_byte   = data;
        r.app_status  = status;
        r.error_code  = code;
        expected_results.push_back(r);
    endfunction

    function automatic void flag_error(input logic [1:0] code);
        err_flag = 1'b1;
        queue_result(KIND_ERROR, '0, '0, code);
    endfunction

    // Header checks in order: version, request id, type, end-request length
    function automatic void check_header();
        logic [15:0] rid;
        logic [15:0] clen;
        rid  = {hdr[HDR_RID_HI], hdr[HDR_RID_LO]};
        clen = {hdr[HDR_CLEN_HI], hdr[HDR_CLEN_LO]};
        if (hdr[HDR_VERSION] != REC_VERSION) begin
            flag_error(ERR_VERSION);
        end else if (rid != req_id) begin
            flag_error(ERR_REQ_ID);
        end else begin
            rec_type = hdr[HDR_TYPE];
            if (rec_type != REC_STDOUT && rec_type != REC_STDERR &&
                rec_type != REC_END_REQ) begin
                flag_error(ERR_TYPE);
            end else if (rec_type == REC_END_REQ && clen != END_BODY_LEN) begin
                flag_error(ERR_END_LEN);
            end else begin
                content_left = clen;
                pad_left     = hdr[HDR_PAD];
                status_acc   = '0;
                // empty record: back to header phase right away
                if (clen == 16'd0 && hdr[HDR_PAD] == 8'd0)
                    hdr_cnt = 4'd0;
            end
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        if (!done_flag && !err_flag) begin
            if (hdr_cnt < 4'd8) begin
                hdr[hdr_cnt[2:0]] = b;
                hdr_cnt = hdr_cnt + 4'd1;
                if (hdr_cnt == 4'd8)
                    check_header();
            end else begin
                if (content_left != 16'd0) begin
                    content_left = content_left - 16'd1;
                    case (rec_type)
                        REC_STDOUT: queue_result(KIND_STDOUT, b, '0, '0);
                        REC_STDERR: queue_result(KIND_STDERR, b, '0, '0);
                        default: begin
                            if (content_left >= 16'd4)
                                status_acc = {status_acc[23:0], b};
                            if (content_left == 16'd0) begin
                                done_flag = 1'b1;
                                queue_result(KIND_DONE, '0, status_acc, '0);
                            end
                        end
                    endcase
                end else if (pad_left != 8'd0) begin
                    pad_left = pad_left - 8'd1;
                end
                if (content_left == 16'd0 && pad_left == 8'd0)
                    hdr_cnt = 4'd0;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        string   got_s;
        string   want_s;
        if (!i_rst_n) begin
            req_id       = '0;
            hdr_cnt      = '0;
            content_left = '0;
            pad_left     = '0;
            rec_type     = '0;
            status_acc   = '0;
            done_flag    = 1'b0;
            err_flag     = 1'b0;
            for (int i = 0; i < 8; i++)
                hdr[i] = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                req_id = i_cfg_wdata;
            if (i_res.valid && i_res.ready) begin
                got = {i_res.kind, i_res.data_byte, i_res.app_status, i_res.error_code};
                got_s = $sformatf("kind=%0d data=%02h status=%08h code=%0d",
                                  got.kind, got.data_byte, got.app_status, got.error_code);
                if (expected_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    $display("%0t: unexpected result: expected none, got %s", $time, got_s);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        want_s = $sformatf("kind=%0d data=%02h status=%08h code=%0d",
                                           want.kind, want.data_byte, want.app_status,
                                           want.error_code);
                        o_fail_count <= o_fail_count + 1;
                        $display("%0t: result mismatch: expected %s, got %s",
                                 $time, want_s, got_s);
                    end
                end
            end
            if (i_rx.valid && i_rx.ready)
                deframe_byte(i_rx.rx_byte);
        end
        o_pending <= expected_results.size();
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ============================================================================
// tb
// Testbench for fastcgi_response_record_parser_top: drives FastCGI record
// streams into the byte channel with random gaps and output stalls, and
// leaves prediction and checking to fcrp_deframe_check.
// ============================================================================
`default_nettype none

module tb
    import fcrp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int SETTLE      = 4;       // latency margin before a config write
    localparam int RAND_BYTES  = 1000;    // bytes to send before the closing part

    // How the stream is ended; the block goes silent after any of these.
    typedef enum {
        TAIL_DONE,
        TAIL_BAD_VERSION,
        TAIL_BAD_ID,
        TAIL_BAD_TYPE,
        TAIL_BAD_LENGTH
    } t_tail;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    fcrp_rx_if  rx_ch();
    fcrp_res_if res_ch();

    int fail_count;
    int pending;
    int n_bytes;
    int cycle_count;
    int sink_stall;

    bit          src_idle_en;
    bit          sink_idle_en;
    bit          hold_req;
    logic [15:0] cur_id;

    fastcgi_response_record_parser_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_res       (res_ch)
    );

    fcrp_deframe_check u_deframe_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** fastcgi_response_record_parser_top: FAILED **");
        $finish;
    end

    // Result sink. Random stall bursts while enabled; a hold request from the
    // stimulus turns into one long hold-off, counted here.
    initial begin
        res_ch.ready = 1'b1;
        sink_stall   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                sink_stall = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            if (sink_stall != 0) begin
                res_ch.ready <= 1'b0;
                sink_stall--;
            end else begin
                res_ch.ready <= 1'b1;
                if (sink_idle_en && $urandom_range(0, 11) == 0)
                    sink_stall = $urandom_range(1, 19);
            end
        end
    end

    // One byte transaction. Valid stays high between back-to-back bytes;
    // a gap burst, when drawn, drops it first.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (src_idle_en && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            rx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        n_bytes++;
    endtask

    // Full record: 8 header bytes, content, padding. With extreme_fill set,
    // content alternates 00/FF and the reserved byte is FF.
    task automatic send_record(input logic [7:0] ver, input logic [7:0] typ,
                               input logic [15:0] rid, input logic [15:0] clen,
                               input logic [7:0] pad, input bit extreme_fill);
        push_byte(ver);
        push_byte(typ);
        push_byte(rid[15:8]);
        push_byte(rid[7:0]);
        push_byte(clen[15:8]);
        push_byte(clen[7:0]);
        push_byte(pad);
        push_byte(extreme_fill ? 8'hFF : 8'($urandom));
        for (int i = 0; i < int'(clen); i++)
            push_byte(extreme_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom));
        repeat (pad) push_byte(8'($urandom));
    endtask

    // Well-formed STDOUT/STDERR record, mostly short, some empty
    task automatic send_random_record();
        logic [7:0]  typ;
        logic [15:0] clen;
        logic [7:0]  pad;
        typ  = ($urandom_range(0, 9) < 5) ? REC_STDOUT : REC_STDERR;
        clen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(17, 40))
                                            : 16'($urandom_range(0, 16));
        pad  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 7)) : 8'd0;
        if ($urandom_range(0, 9) == 0) begin
            clen = 16'd0;
            pad  = 8'd0;
        end
        send_record(REC_VERSION, typ, cur_id, clen, pad, 1'b0);
    endtask

    // Config write only once the block has drained: no byte in flight,
    // every predicted result delivered, plus the SETTLE margin for silent bytes.
    task automatic write_req_id(input logic [15:0] id);
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= id;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_id = id;
    endtask

    // Last record of the stream: either a proper end-request or one of the
    // header errors. Both are terminal until reset.
    task automatic send_tail();
        t_tail       tail;
        logic [7:0]  ver;
        logic [7:0]  typ;
        logic [15:0] rid;
        logic [15:0] clen;
        logic [7:0]  pad;
        tail = t_tail'($urandom_range(0, 4));
        ver  = REC_VERSION;
        typ  = REC_END_REQ;
        rid  = cur_id;
        clen = END_BODY_LEN;
        pad  = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(1, 7));
        case (tail)
            TAIL_BAD_VERSION: begin
                // id and type random too: version must win
                ver = 8'($urandom);
                if (ver == REC_VERSION)
                    ver = 8'h00;
                typ  = 8'($urandom);
                rid  = 16'($urandom);
                clen = 16'($urandom_range(0, 16));
            end
            TAIL_BAD_ID: begin
                rid  = cur_id ^ 16'($urandom_range(1, 65535));
                typ  = 8'($urandom);
                clen = 16'($urandom_range(0, 16));
            end
            TAIL_BAD_TYPE: begin
                do typ = 8'($urandom);
                while (typ == REC_STDOUT || typ == REC_STDERR || typ == REC_END_REQ);
                // also with no content and no padding
                clen = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(1, 16));
            end
            TAIL_BAD_LENGTH: begin
                do clen = 16'($urandom_range(0, 16));
                while (clen == END_BODY_LEN);
            end
            default: ;
        endcase
        send_record(ver, typ, rid, clen, pad, 1'b0);
    endtask

    initial begin
        int ph;
        int stop_at;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        src_idle_en   = 1'b1;
        sink_idle_en  = 1'b1;
        hold_req      = 1'b0;
        n_bytes       = 0;
        cur_id        = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: request id still at its reset value. STDOUT record with
        // 00/FF content and one padding byte, then an empty STDERR record.
        send_record(REC_VERSION, REC_STDOUT, cur_id, 16'd2, 8'd1, 1'b1);
        send_record(REC_VERSION, REC_STDERR, cur_id, 16'd0, 8'd0, 1'b1);

        // Random phases, each with its own request id and idling mix
        ph = 0;
        while (n_bytes < RAND_BYTES) begin
            case (ph)
                0:       write_req_id(16'hFFFF);
                1:       write_req_id(16'h0000);
                default: write_req_id(16'($urandom));
            endcase
            src_idle_en  = ($urandom_range(0, 3) != 0);
            sink_idle_en = ($urandom_range(0, 3) != 0);
            if (ph == 2) begin
                // Sink holds off while a long STDOUT record keeps coming:
                // the output register fills and the byte channel stalls.
                src_idle_en = 1'b0;
                hold_req    = 1'b1;
                send_record(REC_VERSION, REC_STDOUT, cur_id, 16'd300, 8'd0, 1'b0);
                src_idle_en = 1'b1;
            end
            if (ph == 3)
                // padding only, at its largest
                send_record(REC_VERSION, REC_STDERR, cur_id, 16'd0, 8'd255, 1'b0);
            stop_at = n_bytes + $urandom_range(60, 160);
            while (n_bytes < stop_at)
                send_random_record();
            ph++;
        end

        // Closing part: no idling on either side
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        write_req_id(16'($urandom));
        repeat (8) send_random_record();
        send_tail();
        // Bytes after the end transaction must be swallowed
        repeat (16) push_byte(8'($urandom));

        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        if (fail_count == 0)
            $display("** fastcgi_response_record_parser_top: PASSED **");
        else
            $display("** fastcgi_response_record_parser_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
